>>> rtl/ffha_pkg.sv
package ffha_pkg;

    // default heap size in bytes
    localparam int HEAP_BYTES_DEF = 65536;

    // width of internal byte offsets and sums of offsets and sizes
    localparam int OW = 21;

    // width of one stored boundary tag
    localparam int TW = 17;

    // largest heap size the 16-bit payload offset can address
    localparam int OFFSET_CAP = 65536;

    // smallest usable heap
    localparam int HEAP_MIN = 16;

    // header plus footer bytes per block
    localparam int TAG_OVERHEAD = 8;

    // request kinds on tuser
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // result status on tuser
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_OOM = 1'b1;

    // sequencer states
    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_A_RD  = 17'h00002,
        S_A_CHK = 17'h00004,
        S_A_END = 17'h00008,
        S_A_W2  = 17'h00010,
        S_A_W3  = 17'h00020,
        S_A_W4  = 17'h00040,
        S_F_T   = 17'h00080,
        S_F_WF  = 17'h00100,
        S_F_NRD = 17'h00200,
        S_F_NCK = 17'h00400,
        S_F_NW  = 17'h00800,
        S_F_P   = 17'h01000,
        S_F_PCK = 17'h02000,
        S_F_PH  = 17'h04000,
        S_F_PW  = 17'h08000,
        S_DONE  = 17'h10000
    } t_state;

    // size part of a tag, widened to an offset
    function automatic logic [OW-1:0] tag_size(input logic [TW-1:0] tag);
        return {{(OW-TW){1'b0}}, tag[TW-1:3], 3'b000};
    endfunction

endpackage

>>> rtl/ffha_tag_ram.sv
module ffha_tag_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic                   i_re,
    input  logic [AW-1:0]          i_addr,
    input  logic [ffha_pkg::TW-1:0] i_wdata,
    output logic [ffha_pkg::TW-1:0] o_rdata
);
    import ffha_pkg::*;

    logic [TW-1:0] r_mem [DEPTH];
    logic [TW-1:0] r_q;

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

>>> rtl/first_fit_heap_allocator_core.sv
// alloc reads each block header on its walk, then writes the tags and queues the result
// free checks the header, then merges; one single-port tag memory access per cycle paces both
// throughput: one request at a time; the next is taken once the result is queued
// the result register lets a new request in while the last result waits
// reset (synchronous, active low) empties the heap, frontier at offset 4, heap 65536
// tag memory is not cleared: a free whose offset is not a block start can read a tag word never written
module first_fit_heap_allocator_core #(
    parameter int HEAP_BYTES = ffha_pkg::HEAP_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config transfer
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [16:0] i_cfg_data,     // heap_bytes
    // request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // request_bytes[16:0], free_offset[32:17], zero
    input  logic        s_axis_tuser,   // action
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // payload_offset
    output logic        m_axis_tuser    // status
);
    import ffha_pkg::*;

    localparam int TAG_WORDS = HEAP_BYTES / 4;
    localparam int AW = $clog2(TAG_WORDS);
    localparam int CAP_RAW = (HEAP_BYTES > OFFSET_CAP) ? OFFSET_CAP : HEAP_BYTES;
    localparam int CAP = (CAP_RAW / 8) * 8;
    localparam logic [OW-1:0] CAP_W = OW'(CAP);
    localparam logic [OW-1:0] MIN_W = OW'(HEAP_MIN);
    localparam logic [OW-1:0] OVH = OW'(TAG_OVERHEAD);
    localparam logic [OW-3:0] WORDS_W = (OW-2)'(TAG_WORDS);

    t_state        r_state, n_state;
    logic [16:0]   r_heap;
    logic [16:0]   r_front, n_front;
    logic [OW-1:0] r_h, n_h;
    logic [OW-1:0] r_s, n_s;
    logic [OW-1:0] r_r, n_r;
    logic [OW-1:0] r_ps, n_ps;
    logic          r_stat, n_stat;
    logic [15:0]   r_off, n_off;
    logic          r_mvalid;
    logic          r_mstat;
    logic [15:0]   r_moff;
    logic          r_rd_ok;

    logic          mem_we, mem_re;
    logic [OW-1:0] mem_off;
    logic [TW-1:0] mem_wdata;
    logic          mem_in;
    logic [TW-1:0] ram_q;
    logic [TW-1:0] rtag;
    logic [OW-1:0] rsize;
    logic          ralloc;

    logic [OW-1:0] heap_raw, heap_end, front_w, rem, ph;
    logic [16:0]   req_in;
    logic [15:0]   foff_in;
    logic          in_xfer, out_free;

    // effective heap end, rounded down and clamped
    assign heap_raw = {{(OW-17){1'b0}}, r_heap[16:3], 3'b000};
    always_comb begin
        heap_end = heap_raw;
        if (heap_end > CAP_W) begin
            heap_end = CAP_W;
        end
        if (heap_end < MIN_W) begin
            heap_end = MIN_W;
        end
    end

    assign front_w  = {{(OW-17){1'b0}}, r_front};
    assign req_in   = s_axis_tdata[16:0];
    assign foff_in  = s_axis_tdata[32:17];
    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_mvalid || m_axis_tready;

    assign rem = r_s - r_r - OVH;
    assign ph  = r_h - r_ps - OVH;

    // tag read data, zero for words past the store
    assign rtag   = r_rd_ok ? ram_q : '0;
    assign rsize  = tag_size(rtag);
    assign ralloc = rtag[0];

    // tag memory address range check
    assign mem_in = (mem_off[OW-1:2] < WORDS_W);

    ffha_tag_ram #(
        .DEPTH (TAG_WORDS),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we && mem_in),
        .i_re    (mem_re),
        .i_addr  (mem_off[AW+1:2]),
        .i_wdata (mem_wdata),
        .o_rdata (ram_q)
    );

    // allocate and free sequencer
    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_h       = r_h;
        n_s       = r_s;
        n_r       = r_r;
        n_ps      = r_ps;
        n_stat    = r_stat;
        n_off     = r_off;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_off   = r_h;
        mem_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_stat = ST_OK;
                    n_off  = '0;
                    if (s_axis_tuser == ACT_ALLOC) begin
                        n_r     = ({{(OW-17){1'b0}}, req_in} + OW'(7)) & ~OW'(7);
                        n_h     = OW'(4);
                        n_state = S_A_RD;
                    end else if (foff_in[2:0] != 3'b000 || foff_in == 16'd0) begin
                        n_state = S_DONE;
                    end else if (({{(OW-16){1'b0}}, foff_in} - OW'(4)) >= front_w) begin
                        n_state = S_DONE;
                    end else begin
                        n_h     = {{(OW-16){1'b0}}, foff_in} - OW'(4);
                        mem_off = {{(OW-16){1'b0}}, foff_in} - OW'(4);
                        mem_re  = 1'b1;
                        n_state = S_F_T;
                    end
                end
            end
            // walk: fetch the next header
            S_A_RD: begin
                if (r_h < front_w && r_h < heap_end) begin
                    mem_re  = 1'b1;
                    n_state = S_A_CHK;
                end else begin
                    n_state = S_A_END;
                end
            end
            S_A_CHK: begin
                if (!ralloc && rsize >= r_r) begin
                    mem_we    = 1'b1;
                    mem_wdata = TW'(r_r | OW'(1));
                    n_s       = rsize;
                    n_off     = 16'(r_h + OW'(4));
                    n_state   = S_A_W2;
                end else begin
                    n_h     = r_h + rsize + OVH;
                    n_state = S_A_RD;
                end
            end
            // append at the frontier or fail
            S_A_END: begin
                if (front_w + r_r + OVH > heap_end) begin
                    n_stat  = ST_OOM;
                    n_off   = '0;
                    n_state = S_DONE;
                end else begin
                    mem_off   = front_w;
                    mem_we    = 1'b1;
                    mem_wdata = TW'(r_r | OW'(1));
                    n_h       = front_w;
                    n_s       = r_r;
                    n_front   = 17'(front_w + r_r + OVH);
                    n_off     = 16'(front_w + OW'(4));
                    n_state   = S_A_W2;
                end
            end
            S_A_W2: begin
                mem_off   = r_h + OW'(4) + r_r;
                mem_we    = 1'b1;
                mem_wdata = TW'(r_r | OW'(1));
                n_state   = (r_s > r_r) ? S_A_W3 : S_DONE;
            end
            // split remainder header and footer
            S_A_W3: begin
                mem_off   = r_h + r_r + OVH;
                mem_we    = 1'b1;
                mem_wdata = TW'(rem);
                n_state   = S_A_W4;
            end
            S_A_W4: begin
                mem_off   = r_h + r_r + OW'(12) + rem;
                mem_we    = 1'b1;
                mem_wdata = TW'(rem);
                n_state   = S_DONE;
            end
            // free: check header, mark free
            S_F_T: begin
                if (!ralloc || (r_h + OW'(8) + rsize) > front_w) begin
                    n_state = S_DONE;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = TW'(rsize);
                    n_s       = rsize;
                    n_state   = S_F_WF;
                end
            end
            S_F_WF: begin
                mem_off   = r_h + OW'(4) + r_s;
                mem_we    = 1'b1;
                mem_wdata = TW'(r_s);
                if (r_h + r_s + OVH < front_w) begin
                    n_state = S_F_NRD;
                end else begin
                    n_front = 17'(r_h);
                    n_state = S_F_P;
                end
            end
            S_F_NRD: begin
                mem_off = r_h + r_s + OVH;
                mem_re  = 1'b1;
                n_state = S_F_NCK;
            end
            // merge with the next block
            S_F_NCK: begin
                if (!ralloc) begin
                    n_s       = r_s + rsize + OVH;
                    mem_we    = 1'b1;
                    mem_wdata = TW'(r_s + rsize + OVH);
                    n_state   = S_F_NW;
                end else begin
                    n_state = S_F_P;
                end
            end
            S_F_NW: begin
                mem_off   = r_h + OW'(4) + r_s;
                mem_we    = 1'b1;
                mem_wdata = TW'(r_s);
                n_state   = S_F_P;
            end
            // previous block footer
            S_F_P: begin
                if (r_h != OW'(4)) begin
                    mem_off = r_h - OW'(4);
                    mem_re  = 1'b1;
                    n_state = S_F_PCK;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_PCK: begin
                if (rsize + OVH <= r_h - OW'(4)) begin
                    n_ps    = rsize;
                    mem_off = r_h - rsize - OVH;
                    mem_re  = 1'b1;
                    n_state = S_F_PH;
                end else begin
                    n_state = S_DONE;
                end
            end
            // merge with the previous block
            S_F_PH: begin
                if (!ralloc) begin
                    if (front_w == r_h) begin
                        n_front = 17'(ph);
                    end
                    n_s       = r_s + r_ps + OVH;
                    mem_off   = ph;
                    mem_we    = 1'b1;
                    mem_wdata = TW'(r_s + r_ps + OVH);
                    n_state   = S_F_PW;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_F_PW: begin
                mem_off   = ph + OW'(4) + r_s;
                mem_we    = 1'b1;
                mem_wdata = TW'(r_s);
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_front  <= 17'd4;
            r_heap   <= 17'(HEAP_BYTES_DEF);
            r_mvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_front <= n_front;
            if (i_cfg_valid) begin
                r_heap <= i_cfg_data;
            end
            if (r_state == S_DONE && out_free) begin
                r_mvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_mvalid <= 1'b0;
            end
        end
    end

    // working and result payload registers
    always_ff @(posedge i_clk) begin
        r_h     <= n_h;
        r_s     <= n_s;
        r_r     <= n_r;
        r_ps    <= n_ps;
        r_stat  <= n_stat;
        r_off   <= n_off;
        if (mem_re) begin
            r_rd_ok <= mem_in;
        end
        if (r_state == S_DONE && out_free) begin
            r_mstat <= r_stat;
            r_moff  <= r_off;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = r_moff;
    assign m_axis_tuser  = r_mstat;

endmodule

>>> rtl/ffha_checker.sv
module ffha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic        m_axis_tuser
);
    import ffha_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // failed allocation reports offset zero
    a_oom_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OOM) |-> (m_axis_tdata == 16'd0))
        else $error("out of memory with nonzero offset");

    // payload offsets are 8-aligned
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:0] == 3'b000))
        else $error("unaligned payload offset");

    // one request at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while busy");

endmodule

bind first_fit_heap_allocator_core ffha_checker u_ffha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> tb/first_fit_heap_allocator_core_tb.sv
`timescale 1ns / 100ps

module first_fit_heap_allocator_core_tb;
    import ffha_pkg::*;

    localparam int HEAP_CAP   = 65536;
    localparam int TAG_WORDS  = HEAP_CAP / 4;
    localparam int ALLOC_BIT  = 1;
    localparam int SIZE_MASK  = 32'hFFFF_FFF8;
    localparam int RAND_ITEMS = 1950;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [16:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // request_bytes[16:0], free_offset[32:17], zero
    logic        s_axis_tuser;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // payload_offset
    logic        m_axis_tuser;   // status

    first_fit_heap_allocator_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // expected grant: status and payload offset
    typedef struct packed {
        logic        status;
        logic [15:0] offset;
    } t_grant;

    // one directed request with an optional typed-in answer
    typedef struct {
        logic        act;
        int unsigned req;
        int unsigned off;
        bit          typed;
        logic        status;
        int unsigned offset;
    } t_req_row;

    t_grant      grant_q[$];
    int unsigned live_q[$];
    int unsigned freed_q[$];
    int          errors;
    int          results_seen;
    int          oom_seen;
    int          frees_sent;
    bit          hold_rx;

    // shadow heap
    int unsigned tags[TAG_WORDS];
    bit          tag_set[TAG_WORDS];
    int unsigned frontier;
    int unsigned heap_cfg;

    // clock
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic int unsigned tag_get(int unsigned o);
        return ((o >> 2) < TAG_WORDS) ? tags[o >> 2] : 0;
    endfunction

    function automatic void tag_put(int unsigned o, int unsigned v);
        if ((o >> 2) < TAG_WORDS) begin
            tags[o >> 2]    = v;
            tag_set[o >> 2] = 1'b1;
        end
    endfunction

    function automatic int unsigned heap_end();
        int unsigned h;
        h = heap_cfg & SIZE_MASK;
        if (h > HEAP_CAP) h = HEAP_CAP;
        if (h < HEAP_MIN) h = HEAP_MIN;
        return h;
    endfunction

    // first fit walk, split, or append at the frontier
    function automatic t_grant alloc_block(int unsigned req);
        t_grant      g;
        int unsigned r, lim, h, t, s, rem;
        r   = (req + 7) & SIZE_MASK;
        lim = heap_end();
        h   = 4;
        while (h < frontier && h < lim) begin
            t = tag_get(h);
            s = t & SIZE_MASK;
            if (!(t & ALLOC_BIT) && s >= r) begin
                tag_put(h, r | ALLOC_BIT);
                tag_put(h + 4 + r, r | ALLOC_BIT);
                if (s > r) begin
                    rem = s - r - TAG_OVERHEAD;
                    tag_put(h + r + 8, rem);
                    tag_put(h + r + 12 + rem, rem);
                end
                g.status = ST_OK;
                g.offset = 16'(h + 4);
                return g;
            end
            h += s + TAG_OVERHEAD;
        end
        if (frontier + r + TAG_OVERHEAD > lim) begin
            g.status = ST_OOM;
            g.offset = '0;
            return g;
        end
        h = frontier;
        tag_put(h, r | ALLOC_BIT);
        tag_put(h + 4 + r, r | ALLOC_BIT);
        frontier = (h + r + TAG_OVERHEAD) & 32'h1FFFF;
        g.status = ST_OK;
        g.offset = 16'(h + 4);
        return g;
    endfunction

    // release a block and merge with free neighbors
    function automatic void release_block(int unsigned p);
        int unsigned h, t, s, n, foot, nt, ps, ph;
        if ((p & 7) != 0 || p == 0) return;
        h = p - 4;
        if (h >= frontier) return;
        t = tag_get(h);
        if (!(t & ALLOC_BIT)) return;
        s    = t & SIZE_MASK;
        foot = h + 4 + s;
        if (foot + 4 > frontier) return;
        tag_put(h, s);
        tag_put(foot, s);
        n = h + s + TAG_OVERHEAD;
        if (n < frontier) begin
            nt = tag_get(n);
            if (!(nt & ALLOC_BIT)) begin
                s += (nt & SIZE_MASK) + TAG_OVERHEAD;
                tag_put(h, s);
                tag_put(h + 4 + s, s);
            end
        end else begin
            frontier = h;
        end
        if (h != 4) begin
            ps = tag_get(h - 4) & SIZE_MASK;
            if (ps + TAG_OVERHEAD <= h - 4) begin
                ph = h - ps - TAG_OVERHEAD;
                if (!(tag_get(ph) & ALLOC_BIT)) begin
                    if (frontier == h) frontier = ph;
                    s += ps + TAG_OVERHEAD;
                    tag_put(ph, s);
                    tag_put(ph + 4 + s, s);
                end
            end
        end
    endfunction

    function automatic t_grant heap_step(logic act, int unsigned req, int unsigned off);
        t_grant g;
        if (act == ACT_ALLOC) begin
            g = alloc_block(req);
            if (g.status == ST_OK) live_q.push_back(g.offset);
        end else begin
            release_block(off);
            foreach (live_q[i]) if (live_q[i] == off) begin
                live_q.delete(i);
                break;
            end
            freed_q.push_back(off);
            if (freed_q.size() > 32) void'(freed_q.pop_front());
            g = '0;
        end
        return g;
    endfunction

    // a free never reads a tag word that was never written
    function automatic bit free_is_safe(int unsigned p);
        if ((p & 7) != 0 || p == 0 || p - 4 >= frontier) return 1'b1;
        return tag_set[(p - 4) >> 2];
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // request transfer; the grant is predicted at acceptance
    task automatic send_req(logic act, int unsigned req, int unsigned off,
                            bit typed, t_grant typed_g);
        bit     rdy;
        t_grant g;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {7'b0, off[15:0], req[16:0]};
        do begin
            #1 rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        g = heap_step(act, req, off);
        grant_q.push_back(typed ? typed_g : g);
        if (act == ACT_FREE) frees_sent++;
    endtask

    task automatic tx_gap();
        int n;
        n = ($urandom_range(0, 99) < 60) ? 0 :
            ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(20, 60);
        if (n > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register transfer, only with the block idle
    task automatic write_heap(int unsigned v);
        bit rdy;
        drain();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = v[16:0];
        do begin
            #1 rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        heap_cfg = v & 32'h1FFFF;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_req();
        int unsigned req, off, k;
        int          pick;
        t_grant      none;
        none = '0;
        pick = $urandom_range(0, 99);
        if (pick < 55 || (pick < 85 && live_q.size() == 0)) begin
            k   = $urandom_range(0, 99);
            req = (k < 75) ? $urandom_range(0, 96) :
                  (k < 95) ? $urandom_range(97, 2048) : $urandom_range(0, 131071);
            send_req(ACT_ALLOC, req, $urandom_range(0, 65535), 1'b0, none);
        end else if (pick < 85) begin
            off = live_q[$urandom_range(0, live_q.size() - 1)];
            send_req(ACT_FREE, $urandom_range(0, 131071), off, 1'b0, none);
        end else begin
            off = (freed_q.size() != 0 && pick < 92) ?
                  freed_q[$urandom_range(0, freed_q.size() - 1)] : $urandom_range(0, 65535);
            if (!free_is_safe(off)) off = off | 1;
            send_req(ACT_FREE, $urandom_range(0, 131071), off, 1'b0, none);
        end
    endtask

    // receiver: random tready, one long hold, result check
    initial begin
        bit     fire;
        t_grant got, want;
        int     n;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                m_axis_tready = 1'b0;
                for (n = 0; n < 400; n++) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            m_axis_tready = ($urandom_range(0, 99) < 97) ? ($urandom_range(0, 99) < 75) : 1'b0;
            #1;
            fire = m_axis_tvalid && m_axis_tready;
            got  = {m_axis_tuser, m_axis_tdata};
            @(posedge i_clk);
            if (fire) begin
                results_seen++;
                if (got.status == ST_OOM) oom_seen++;
                if (grant_q.size() == 0) begin
                    report_mismatch("unexpected result", got, 0);
                end else begin
                    want = grant_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.offset != want.offset)
                        report_mismatch("payload_offset", got.offset, want.offset);
                end
            end
        end
    end

    // run limit, well above a full-heap walk for every request
    initial begin
        repeat (200) #20_000_000;
        $display("[first_fit_heap_allocator_core] ERROR");
        $finish;
    end

    // directed rows: reset heap first, typed answers for the obvious ones
    t_req_row rows[] = '{
        '{ACT_ALLOC, 0,      0,     1, ST_OK,  8},     // zero size block
        '{ACT_ALLOC, 1,      0,     1, ST_OK,  16},
        '{ACT_ALLOC, 64,     0,     1, ST_OK,  32},
        '{ACT_ALLOC, 8,      0,     1, ST_OK,  104},
        '{ACT_FREE,  0,      32,    1, ST_OK,  0},
        '{ACT_ALLOC, 16,     0,     0, ST_OK,  0},     // split of the freed block
        '{ACT_ALLOC, 65536,  0,     1, ST_OOM, 0},
        '{ACT_ALLOC, 131071, 0,     1, ST_OOM, 0},
        '{ACT_FREE,  131071, 65535, 1, ST_OK,  0},     // unaligned offset ignored
        '{ACT_FREE,  0,      0,     1, ST_OK,  0},     // offset zero ignored
        '{ACT_FREE,  0,      65528, 1, ST_OK,  0},     // past the frontier
        '{ACT_FREE,  0,      32,    1, ST_OK,  0},
        '{ACT_FREE,  0,      32,    1, ST_OK,  0},     // double free
        '{ACT_FREE,  0,      104,   0, ST_OK,  0},     // last block, frontier pulled back
        '{ACT_FREE,  0,      16,    0, ST_OK,  0},     // last block, frontier pulled back
        '{ACT_ALLOC, 24,     0,     0, ST_OK,  0},
        '{ACT_ALLOC, 7,      0,     0, ST_OK,  0},
        '{ACT_FREE,  0,      8,     0, ST_OK,  0},
        '{ACT_ALLOC, 65000,  0,     0, ST_OK,  0}
    };

    // heap sizes walked by the random phases
    int unsigned heap_sizes[] = '{65536, 16, 64, 256, 1000, 4096, 131071, 0, 65536};

    initial begin
        t_grant tg;
        int     i, p;
        errors = 0; results_seen = 0; oom_seen = 0; frees_sent = 0; hold_rx = 1'b0;
        i_rst_n = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = ACT_ALLOC;
        foreach (tags[k]) begin
            tags[k] = 0;
            tag_set[k] = 1'b0;
        end
        frontier = 4;
        heap_cfg = HEAP_CAP;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[k]) begin
            tg.status = rows[k].status;
            tg.offset = 16'(rows[k].offset);
            send_req(rows[k].act, rows[k].req, rows[k].off, rows[k].typed, tg);
            tx_gap();
        end

        for (p = 0; p < heap_sizes.size(); p++) begin
            write_heap(heap_sizes[p]);
            for (i = 0; i < RAND_ITEMS / heap_sizes.size(); i++) begin
                if (p == 1 && i == 10) hold_rx = 1'b1;
                if (p == 5 && i == 50) drain();
                random_req();
                tx_gap();
            end
        end

        drain();
        $display("covered %0d results, %0d out of memory, %0d frees, over %0d heap sizes",
                 results_seen, oom_seen, frees_sent, heap_sizes.size());
        if (errors == 0 && grant_q.size() == 0) begin
            $display("[first_fit_heap_allocator_core] OK");
        end else begin
            $display("[first_fit_heap_allocator_core] ERROR");
        end
        $finish;
    end

endmodule
